// ----- rtl/prt_pkg.sv -----
`timescale 1ns / 1ps
package prt_pkg;

  localparam logic [1:0] OP_GEN   = 2'd0;
  localparam logic [1:0] OP_REPLY = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  localparam logic [2:0] REG_PROBING_ENABLED = 3'd0;
  localparam logic [2:0] REG_PROBE_LIMIT     = 3'd1;
  localparam logic [2:0] REG_INIT_SEQ_MIN    = 3'd2;
  localparam logic [2:0] REG_INIT_SEQ_MAX    = 3'd3;
  localparam logic [2:0] REG_RTT_SEQ_MIN     = 3'd4;
  localparam logic [2:0] REG_RTT_SEQ_MAX     = 3'd5;
  localparam logic [2:0] REG_AGE_LIMIT_MS    = 3'd6;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INIT = 2'd1;
  localparam logic [1:0] KIND_RTT  = 2'd2;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [16:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq;
    logic        reply_valid;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic        probe_issued;
    logic [31:0] probe_seq;
    logic [31:0] rtt_ms;
    logic [1:0]  probe_kind;
    logic [15:0] sent_count;
    logic [15:0] recv_count;
    logic        batch_valid;
    logic [16:0] loss_rate_q16;
    logic        table_full;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_COUNT,
    ST_PURGE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic count_step;
    logic purge_step;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_gen_issue;
    logic need_purge;
    logic count_done;
    logic purge_done;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/prt_datapath.sv -----
`timescale 1ns / 1ps
module prt_datapath #(
  parameter int PENDING_LIMIT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  prt_pkg::in_word_t   in_word,
  input  prt_pkg::cmd_t       cmd,
  output prt_pkg::sts_t       sts,
  output prt_pkg::out_word_t  res
);

  localparam int DEPTH = PENDING_LIMIT + 1;
  localparam int IW = $clog2(DEPTH + 1);

  logic        probing_enabled;
  logic [15:0] probe_limit;
  logic [31:0] init_seq_min, init_seq_max, rtt_seq_min, rtt_seq_max;
  logic [15:0] age_limit_ms;

  logic [31:0] entry_seq [DEPTH];
  logic [31:0] entry_time [DEPTH];
  logic [DEPTH-1:0] entry_used;
  logic [15:0] sent_total, recv_total;
  logic        batch_ok, active;

  prt_pkg::in_word_t cur;
  logic [IW-1:0] idx;
  logic [IW-1:0] found_idx, free_idx;
  logic          found, free_ok;
  logic [IW-1:0] used_cnt;
  logic [31:0]   rtt;
  logic          issued, full;

  logic [15:0] quot;
  logic [15:0] rem;
  logic [4:0]  div_cnt;
  logic [15:0] dividend;
  logic [16:0] div_trial;
  logic [16:0] div_diff;

  // restoring divider, remainder starts at recv_total and brings down the rounding term
  assign div_trial = {rem, dividend[15]};
  assign div_diff = div_trial - {1'b0, sent_total};

  logic [IW-1:0] idx_sel;
  logic          idx_end;
  assign idx_sel = idx;
  assign idx_end = (idx == IW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      probing_enabled <= 1'b0;
      probe_limit <= '0;
      init_seq_min <= '0;
      init_seq_max <= '0;
      rtt_seq_min <= '0;
      rtt_seq_max <= '0;
      age_limit_ms <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        prt_pkg::REG_PROBING_ENABLED: probing_enabled <= cfg_data[0];
        prt_pkg::REG_PROBE_LIMIT: probe_limit <= cfg_data[15:0];
        prt_pkg::REG_INIT_SEQ_MIN: init_seq_min <= cfg_data;
        prt_pkg::REG_INIT_SEQ_MAX: init_seq_max <= cfg_data;
        prt_pkg::REG_RTT_SEQ_MIN: rtt_seq_min <= cfg_data;
        prt_pkg::REG_RTT_SEQ_MAX: rtt_seq_max <= cfg_data;
        prt_pkg::REG_AGE_LIMIT_MS: age_limit_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign sts.scan_done = idx_end;
  assign sts.count_done = idx_end;
  assign sts.purge_done = idx_end;
  assign sts.is_gen_issue = issued;
  assign sts.need_purge = (used_cnt > IW'(PENDING_LIMIT));
  assign sts.div_done = (div_cnt == 5'd16);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_used <= '0;
      sent_total <= '0;
      recv_total <= '0;
      batch_ok <= 1'b1;
      active <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      free_ok <= 1'b0;
      issued <= 1'b0;
      full <= 1'b0;
      used_cnt <= '0;
      div_cnt <= '0;
    end else begin
      if (cmd.load) begin
        cur <= in_word;
      end
      if (cmd.scan_start) begin
        idx <= '0;
        found <= 1'b0;
        free_ok <= 1'b0;
        found_idx <= '0;
        free_idx <= '0;
        issued <= 1'b0;
        full <= 1'b0;
        rtt <= '0;
      end
      if (cmd.scan_step) begin
        if (entry_used[idx_sel] && entry_seq[idx_sel] == cur.seq && !found) begin
          found <= 1'b1;
          found_idx <= idx_sel;
        end
        if (!entry_used[idx_sel] && !free_ok) begin
          free_ok <= 1'b1;
          free_idx <= idx_sel;
        end
        idx <= idx_end ? '0 : idx + 1'b1;
      end
      if (cmd.decide) begin
        used_cnt <= '0;
        case (cur.op)
          prt_pkg::OP_GEN: begin
            if (active && !(probe_limit != 16'd0 && sent_total >= probe_limit)) begin
              issued <= 1'b1;
              if (!found) begin
                if (free_ok) begin
                  entry_used[free_idx] <= 1'b1;
                  entry_seq[free_idx] <= cur.seq;
                  entry_time[free_idx] <= cur.now_ms;
                end else begin
                  full <= 1'b1;
                end
              end
              if (sent_total != prt_pkg::CNT_MAX) sent_total <= sent_total + 16'd1;
            end
          end
          prt_pkg::OP_REPLY: begin
            if (found) begin
              entry_used[found_idx] <= 1'b0;
              if (!cur.reply_valid) begin
                batch_ok <= 1'b0;
              end else begin
                rtt <= (cur.now_ms == entry_time[found_idx]) ? 32'd1 :
                       cur.now_ms - entry_time[found_idx];
                if (recv_total != prt_pkg::CNT_MAX) recv_total <= recv_total + 16'd1;
              end
            end
          end
          prt_pkg::OP_STOP: begin
            sent_total <= '0;
            recv_total <= '0;
            batch_ok <= 1'b1;
            active <= 1'b0;
          end
          default: begin
            sent_total <= '0;
            recv_total <= '0;
            batch_ok <= 1'b1;
            active <= probing_enabled;
          end
        endcase
      end
      if (cmd.count_step) begin
        used_cnt <= used_cnt + IW'(entry_used[idx_sel]);
        idx <= idx_end ? '0 : idx + 1'b1;
      end
      if (cmd.purge_step) begin
        if (entry_used[idx_sel] &&
            (cur.now_ms - entry_time[idx_sel]) > {16'd0, age_limit_ms}) begin
          entry_used[idx_sel] <= 1'b0;
        end
        idx <= idx_end ? '0 : idx + 1'b1;
      end
      if (cmd.div_start) begin
        div_cnt <= '0;
        quot <= '0;
        rem <= recv_total;
        dividend <= {1'b0, sent_total[15:1]};
      end
      if (cmd.div_step) begin
        dividend <= {dividend[14:0], 1'b0};
        if (div_trial >= {1'b0, sent_total}) begin
          rem <= div_diff[15:0];
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem <= div_trial[15:0];
          quot <= {quot[14:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
    end
  end

  logic [1:0] kind;
  always_comb begin
    if (init_seq_min <= cur.seq && cur.seq <= init_seq_max) kind = prt_pkg::KIND_INIT;
    else if (rtt_seq_min <= cur.seq && cur.seq <= rtt_seq_max) kind = prt_pkg::KIND_RTT;
    else kind = prt_pkg::KIND_NONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.probe_issued <= issued;
      res.probe_seq <= issued ? cur.seq : 32'd0;
      res.rtt_ms <= rtt;
      res.probe_kind <= kind;
      res.sent_count <= sent_total;
      res.recv_count <= recv_total;
      res.batch_valid <= batch_ok;
      res.table_full <= full;
      if (!batch_ok || sent_total == 16'd0) res.loss_rate_q16 <= prt_pkg::Q16_ONE;
      else if (recv_total >= sent_total) res.loss_rate_q16 <= '0;
      else res.loss_rate_q16 <= prt_pkg::Q16_ONE - {1'b0, quot};
    end
  end

endmodule

// ----- rtl/prt_ctrl.sv -----
`timescale 1ns / 1ps
module prt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  prt_pkg::sts_t sts,
  output prt_pkg::cmd_t cmd
);

  prt_pkg::state_t state, state_next;
  logic out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::ST_IDLE;
      out_busy <= 1'b0;
    end else begin
      state <= state_next;
      if (state == prt_pkg::ST_OUT) out_busy <= 1'b1;
      else if (!out_stall) out_busy <= 1'b0;
    end
  end

  assign out_valid = out_busy;
  assign in_stall = (state != prt_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      prt_pkg::ST_IDLE: if (in_valid) state_next = prt_pkg::ST_SCAN;
      prt_pkg::ST_SCAN: if (sts.scan_done) state_next = prt_pkg::ST_DECIDE;
      prt_pkg::ST_DECIDE: state_next = prt_pkg::ST_COUNT;
      prt_pkg::ST_COUNT: if (sts.count_done)
        state_next = prt_pkg::ST_PURGE;
      prt_pkg::ST_PURGE: if (!sts.is_gen_issue || !sts.need_purge || sts.purge_done)
        state_next = prt_pkg::ST_DIV;
      prt_pkg::ST_DIV: if (sts.div_done && (!out_busy || !out_stall))
        state_next = prt_pkg::ST_OUT;
      prt_pkg::ST_OUT: state_next = prt_pkg::ST_IDLE;
      default: state_next = prt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      prt_pkg::ST_IDLE: begin
        cmd.load = in_valid;
        cmd.scan_start = in_valid;
      end
      prt_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      prt_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.div_start = 1'b0;
      end
      prt_pkg::ST_COUNT: begin
        cmd.count_step = 1'b1;
        cmd.div_start = sts.count_done;
      end
      prt_pkg::ST_PURGE: cmd.purge_step = sts.is_gen_issue && sts.need_purge;
      prt_pkg::ST_DIV: cmd.div_step = !sts.div_done;
      prt_pkg::ST_OUT: cmd.out_load = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- rtl/probe_rtt_tracker.sv -----
`timescale 1ns / 1ps
// per word: a table scan, a decision, a count pass, a purge pass when an issued probe leaves
// more than PENDING_LIMIT entries in use, the 16-step divider and the output load; in_stall
// holds the next word until the FSM is back in idle; a held result stalls it at the divider
// reset: synchronous active-high rst clears the table valid bits, counters, batch state
// and registers (age limit to 1000); no clearing pass
module probe_rtt_tracker #(
  parameter int PENDING_LIMIT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  prt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output prt_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  prt_pkg::cmd_t cmd;
  prt_pkg::sts_t sts;

  prt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  prt_datapath #(.PENDING_LIMIT(PENDING_LIMIT)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_word(in_data), .cmd(cmd), .sts(sts), .res(out_data)
  );

endmodule
